[hdl/dtq_pkg.sv]
`default_nettype none
package dtq_pkg;

	localparam int NUM_TIMERS_DEF = 16;
	localparam int TICK_WIDTH_DEF = 32;

	// input item kinds
	localparam logic [1:0] KIND_TICK   = 2'd0;
	localparam logic [1:0] KIND_START  = 2'd1;
	localparam logic [1:0] KIND_CANCEL = 2'd2;
	localparam logic [1:0] KIND_READ   = 2'd3;

	// result kinds
	localparam logic [1:0] RES_EXPIRED = 2'd0;
	localparam logic [1:0] RES_REMAIN  = 2'd1;
	localparam logic [1:0] RES_NEXT    = 2'd2;
	localparam logic [1:0] RES_EMPTY   = 2'd3;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_EMIT_EMPTY,
		OP_EMIT_ZERO,
		OP_TICK_BEGIN,
		OP_TICK_STEP,
		OP_WALK_BEGIN,
		OP_READ_STEP,
		OP_UNLINK_STEP,
		OP_FIX,
		OP_EMIT_REM,
		OP_INS_BEGIN,
		OP_INS_STEP,
		OP_INS_FIN1,
		OP_INS_FIN2
	} op_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       id_valid;
		logic       id_ok;
		logic       head_nil;
		logic       found;
		logic       link_nil;
		logic       expire;
		logic       ins_lt;
	} status_t;

endpackage
`default_nettype wire

[hdl/dtq_ram.sv]
`default_nettype none
module dtq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[hdl/dtq_ctrl.sv]
`default_nettype none
module dtq_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire dtq_pkg::status_t stat,
	output dtq_pkg::op_t          op,
	output logic                  busy
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_TICK_WALK,
		ST_TICK_EMPTY,
		ST_READ_WALK,
		ST_UNLINK,
		ST_UNLINK_FIX,
		ST_UNLINK_DONE,
		ST_INS_START,
		ST_INS_WALK,
		ST_INS_FIN1,
		ST_INS_FIN2
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		op      = dtq_pkg::OP_NOP;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					op      = dtq_pkg::OP_LOAD;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (stat.kind)
					dtq_pkg::KIND_TICK: begin
						if (stat.head_nil) begin
							op      = dtq_pkg::OP_EMIT_EMPTY;
							state_d = ST_IDLE;
						end else begin
							op      = dtq_pkg::OP_TICK_BEGIN;
							state_d = ST_TICK_WALK;
						end
					end
					dtq_pkg::KIND_START: begin
						priority if (!stat.id_valid) begin
							state_d = ST_IDLE;
						end else if (stat.id_ok) begin
							op      = dtq_pkg::OP_WALK_BEGIN;
							state_d = ST_UNLINK;
						end else begin
							state_d = ST_INS_START;
						end
					end
					dtq_pkg::KIND_CANCEL: begin
						if (stat.id_ok) begin
							op      = dtq_pkg::OP_WALK_BEGIN;
							state_d = ST_UNLINK;
						end else begin
							op      = dtq_pkg::OP_EMIT_ZERO;
							state_d = ST_IDLE;
						end
					end
					default: begin
						if (stat.id_ok) begin
							op      = dtq_pkg::OP_WALK_BEGIN;
							state_d = ST_READ_WALK;
						end else begin
							op      = dtq_pkg::OP_EMIT_ZERO;
							state_d = ST_IDLE;
						end
					end
				endcase
			end
			ST_TICK_WALK: begin
				op = dtq_pkg::OP_TICK_STEP;
				if (!stat.expire) begin
					state_d = ST_IDLE;
				end else if (stat.link_nil) begin
					state_d = ST_TICK_EMPTY;
				end
			end
			ST_TICK_EMPTY: begin
				op      = dtq_pkg::OP_EMIT_EMPTY;
				state_d = ST_IDLE;
			end
			ST_READ_WALK: begin
				op = dtq_pkg::OP_READ_STEP;
				if (stat.found) begin
					state_d = ST_IDLE;
				end
			end
			ST_UNLINK: begin
				op = dtq_pkg::OP_UNLINK_STEP;
				if (stat.found) begin
					state_d = stat.link_nil ? ST_UNLINK_DONE : ST_UNLINK_FIX;
				end
			end
			ST_UNLINK_FIX: begin
				op      = dtq_pkg::OP_FIX;
				state_d = ST_UNLINK_DONE;
			end
			ST_UNLINK_DONE: begin
				if (stat.kind == dtq_pkg::KIND_CANCEL) begin
					op      = dtq_pkg::OP_EMIT_REM;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_INS_START;
				end
			end
			ST_INS_START: begin
				op      = dtq_pkg::OP_INS_BEGIN;
				state_d = stat.head_nil ? ST_INS_FIN1 : ST_INS_WALK;
			end
			ST_INS_WALK: begin
				op = dtq_pkg::OP_INS_STEP;
				if (stat.ins_lt || stat.link_nil) begin
					state_d = ST_INS_FIN1;
				end
			end
			ST_INS_FIN1: begin
				op      = dtq_pkg::OP_INS_FIN1;
				state_d = ST_INS_FIN2;
			end
			ST_INS_FIN2: begin
				op      = dtq_pkg::OP_INS_FIN2;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy    <= 1'b0;
		end else begin
			state_q <= state_d;
			busy    <= (state_d != ST_IDLE);
		end
	end

	a_busy_track: assert property (@(posedge clk) disable iff (!arst_n)
		busy == (state_q != ST_IDLE))
		else $error("busy out of step with state");

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_DECODE))
		else $error("accepted item not decoded");

	a_walk_after_find: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UNLINK && stat.found) |=>
		(state_q == ST_UNLINK_FIX || state_q == ST_UNLINK_DONE))
		else $error("unlink did not finish after find");

endmodule
`default_nettype wire

[hdl/dtq_dpath.sv]
`default_nettype none
module dtq_dpath #(
	parameter int NUM_TIMERS = dtq_pkg::NUM_TIMERS_DEF,
	parameter int TICK_WIDTH = dtq_pkg::TICK_WIDTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire dtq_pkg::op_t     op,
	output dtq_pkg::status_t      stat,
	input  wire logic [1:0]       kind,
	input  wire logic [3:0]       timer_id,
	input  wire logic [31:0]      duration,
	input  wire logic [15:0]      elapsed_ticks,
	output logic                  result_valid,
	output logic [1:0]            result_kind,
	output logic [3:0]            result_timer,
	output logic [31:0]           remaining,
	output logic                  last
);

	localparam int AW = $clog2(NUM_TIMERS);
	localparam int SW = $clog2(NUM_TIMERS + 1);
	localparam int DW = ((TICK_WIDTH > 16) ? TICK_WIDTH : 16) + 2;
	localparam logic [SW-1:0] NIL = SW'(NUM_TIMERS);
	localparam logic [63:0] TMAX = (64'd1 << TICK_WIDTH) - 64'd1;

	logic [1:0]              kind_q;
	logic [3:0]              id_q;
	logic [31:0]             dur_q;
	logic [15:0]             elap_q;
	logic [SW-1:0]           head_q, cur_q, prev_q;
	logic [NUM_TIMERS-1:0]   active_q;
	logic signed [DW-1:0]    work_q, dlt_q;

	logic [DW-1:0]           rd_delta_raw;
	logic signed [DW-1:0]    rd_delta;
	logic [SW-1:0]           rd_link;
	logic [AW-1:0]           raddr, d_waddr, l_waddr;
	logic                    d_we, l_we;
	logic signed [DW-1:0]    d_wdata;
	logic [SW-1:0]           l_wdata;

	logic [SW-1:0]           id_slot;
	logic                    id_valid, id_ok, prev_ok, found, expire, ins_lt;
	logic signed [DW-1:0]    sum, ins_diff, ins_rem, dsat;
	logic [63:0]             dur64;

	function automatic logic [31:0] clamp32(input logic signed [DW-1:0] v);
		logic signed [63:0] w;
		w = 64'(v);
		if (w < 0) begin
			return 32'd0;
		end else if (w > 64'sh0000_0000_FFFF_FFFF) begin
			return 32'hFFFF_FFFF;
		end
		return w[31:0];
	endfunction

	dtq_ram #(.WIDTH(DW), .DEPTH(NUM_TIMERS)) u_delta (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.raddr (raddr),
		.rdata (rd_delta_raw)
	);

	dtq_ram #(.WIDTH(SW), .DEPTH(NUM_TIMERS)) u_link (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.raddr (raddr),
		.rdata (rd_link)
	);

	assign rd_delta = $signed(rd_delta_raw);
	assign id_slot  = SW'(id_q);
	assign id_valid = (32'(id_q) < 32'(NUM_TIMERS));
	assign id_ok    = id_valid && active_q[id_slot[AW-1:0]];
	assign prev_ok  = (prev_q != NIL);
	assign found    = (cur_q == id_slot);
	assign sum      = work_q + rd_delta;
	assign expire   = (sum <= 0);
	assign ins_lt   = (work_q < rd_delta);
	assign ins_diff = rd_delta - work_q;
	assign ins_rem  = work_q - rd_delta;
	assign dur64    = 64'(dur_q);
	assign dsat     = DW'((dur64 > TMAX) ? TMAX : dur64);

	always_comb begin
		stat.kind     = kind_q;
		stat.id_valid = id_valid;
		stat.id_ok    = id_ok;
		stat.head_nil = (head_q == NIL);
		stat.found    = found;
		stat.link_nil = (rd_link == NIL);
		stat.expire   = expire;
		stat.ins_lt   = ins_lt;
	end

	// memory ports
	always_comb begin
		raddr   = head_q[AW-1:0];
		d_we    = 1'b0;
		d_waddr = cur_q[AW-1:0];
		d_wdata = sum;
		l_we    = 1'b0;
		l_waddr = prev_q[AW-1:0];
		l_wdata = rd_link;
		unique case (op)
			dtq_pkg::OP_TICK_STEP: begin
				raddr = rd_link[AW-1:0];
				d_we  = !expire;
			end
			dtq_pkg::OP_READ_STEP: begin
				raddr = rd_link[AW-1:0];
			end
			dtq_pkg::OP_UNLINK_STEP: begin
				raddr = rd_link[AW-1:0];
				l_we  = found && prev_ok;
			end
			dtq_pkg::OP_FIX: begin
				d_we    = 1'b1;
				d_wdata = rd_delta + dlt_q;
			end
			dtq_pkg::OP_INS_STEP: begin
				raddr   = rd_link[AW-1:0];
				d_we    = ins_lt;
				d_wdata = ins_diff;
			end
			dtq_pkg::OP_INS_FIN1: begin
				d_we    = 1'b1;
				d_waddr = id_slot[AW-1:0];
				d_wdata = work_q;
				l_we    = 1'b1;
				l_waddr = id_slot[AW-1:0];
				l_wdata = cur_q;
			end
			dtq_pkg::OP_INS_FIN2: begin
				l_we    = prev_ok;
				l_wdata = id_slot;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= NIL;
			active_q     <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			unique case (op)
				dtq_pkg::OP_EMIT_EMPTY, dtq_pkg::OP_EMIT_ZERO,
				dtq_pkg::OP_EMIT_REM: begin
					result_valid <= 1'b1;
				end
				dtq_pkg::OP_TICK_STEP: begin
					result_valid <= 1'b1;
					if (expire) begin
						active_q[cur_q[AW-1:0]] <= 1'b0;
						head_q <= rd_link;
					end
				end
				dtq_pkg::OP_READ_STEP: begin
					result_valid <= found;
				end
				dtq_pkg::OP_UNLINK_STEP: begin
					if (found) begin
						active_q[id_slot[AW-1:0]] <= 1'b0;
						if (!prev_ok) begin
							head_q <= rd_link;
						end
					end
				end
				dtq_pkg::OP_INS_FIN2: begin
					active_q[id_slot[AW-1:0]] <= 1'b1;
					if (!prev_ok) begin
						head_q <= id_slot;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			dtq_pkg::OP_LOAD: begin
				kind_q <= kind;
				id_q   <= timer_id;
				dur_q  <= duration;
				elap_q <= elapsed_ticks;
			end
			dtq_pkg::OP_EMIT_EMPTY: begin
				result_kind  <= dtq_pkg::RES_EMPTY;
				result_timer <= 4'd0;
				remaining    <= 32'd0;
				last         <= 1'b1;
			end
			dtq_pkg::OP_EMIT_ZERO: begin
				result_kind  <= dtq_pkg::RES_REMAIN;
				result_timer <= id_q;
				remaining    <= 32'd0;
				last         <= 1'b1;
			end
			dtq_pkg::OP_TICK_BEGIN: begin
				cur_q  <= head_q;
				work_q <= -$signed(DW'(elap_q));
			end
			dtq_pkg::OP_TICK_STEP: begin
				result_timer <= 4'(cur_q);
				if (expire) begin
					// carry lateness into the next entry
					work_q       <= sum;
					cur_q        <= rd_link;
					result_kind  <= dtq_pkg::RES_EXPIRED;
					remaining    <= 32'd0;
					last         <= 1'b0;
				end else begin
					result_kind  <= dtq_pkg::RES_NEXT;
					remaining    <= clamp32(sum);
					last         <= 1'b1;
				end
			end
			dtq_pkg::OP_WALK_BEGIN: begin
				cur_q  <= head_q;
				prev_q <= NIL;
				work_q <= '0;
			end
			dtq_pkg::OP_READ_STEP: begin
				if (found) begin
					result_kind  <= dtq_pkg::RES_REMAIN;
					result_timer <= id_q;
					remaining    <= clamp32(sum);
					last         <= 1'b1;
				end else begin
					work_q <= sum;
					cur_q  <= rd_link;
				end
			end
			dtq_pkg::OP_UNLINK_STEP: begin
				work_q <= sum;
				cur_q  <= rd_link;
				if (found) begin
					dlt_q <= rd_delta;
				end else begin
					prev_q <= cur_q;
				end
			end
			dtq_pkg::OP_EMIT_REM: begin
				result_kind  <= dtq_pkg::RES_REMAIN;
				result_timer <= id_q;
				remaining    <= clamp32(work_q);
				last         <= 1'b1;
			end
			dtq_pkg::OP_INS_BEGIN: begin
				cur_q  <= head_q;
				prev_q <= NIL;
				work_q <= dsat;
			end
			dtq_pkg::OP_INS_STEP: begin
				if (!ins_lt) begin
					work_q <= ins_rem;
					prev_q <= cur_q;
					cur_q  <= rd_link;
				end
			end
			default: begin
			end
		endcase
	end

	a_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == NIL) == (active_q == '0))
		else $error("list head and active slots disagree");

	a_head_active: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q != NIL) |-> active_q[head_q[AW-1:0]])
		else $error("head slot not active");

	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last) |=> result_valid)
		else $error("gap inside a result burst");

endmodule
`default_nettype wire

[hdl/delta_timer_queue.sv]
`default_nettype none
// Delta-list timer queue: one item at a time, busy high from accept until the item is done.
// Tick: E expired results, then a next-timer or empty result, all in consecutive cycles.
// Read and cancel walk the N queued entries one a cycle.
// Start: an unlink walk of an active timer, then an insert walk.
// The walk rate is set by the registered read of the delta and link memories.
// Reset clears the list and active bits at once; the receiver cannot stall results.
module delta_timer_queue #(
	parameter int NUM_TIMERS = dtq_pkg::NUM_TIMERS_DEF,
	parameter int TICK_WIDTH = dtq_pkg::TICK_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  kind,
	input  wire logic [3:0]  timer_id,
	input  wire logic [31:0] duration,
	input  wire logic [15:0] elapsed_ticks,
	output logic             result_valid,
	output logic [1:0]       result_kind,
	output logic [3:0]       result_timer,
	output logic [31:0]      remaining,
	output logic             last
);

	dtq_pkg::op_t     op;
	dtq_pkg::status_t stat;

	dtq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.op     (op),
		.busy   (busy)
	);

	dtq_dpath #(.NUM_TIMERS(NUM_TIMERS), .TICK_WIDTH(TICK_WIDTH)) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.stat          (stat),
		.kind          (kind),
		.timer_id      (timer_id),
		.duration      (duration),
		.elapsed_ticks (elapsed_ticks),
		.result_valid  (result_valid),
		.result_kind   (result_kind),
		.result_timer  (result_timer),
		.remaining     (remaining),
		.last          (last)
	);

endmodule
`default_nettype wire
